@@ design/sfc_pkg.sv @@
package sfc_pkg;

	localparam int unsigned COMP_W = 16;
	localparam int unsigned MAXF_W = 15;
	localparam int unsigned NUM_W  = 22;  // |component| * 64
	localparam int unsigned LEN_W  = 16;  // floor sqrt of a 32-bit radicand
	localparam int unsigned RAD_W  = 32;
	localparam int unsigned SQ_W   = 26;  // sum of three floored squares
	localparam int unsigned LIM_W  = 24;
	localparam int unsigned MUL_A_W = 24;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int unsigned FRAC_W = 6;

	typedef struct packed {
		logic signed [COMP_W-1:0] force_x;
		logic signed [COMP_W-1:0] force_y;
		logic signed [COMP_W-1:0] force_z;
		logic signed [COMP_W-1:0] weight;
		logic [MAXF_W-1:0]        max_force;
		logic                     enabled;
		logic                     last;
	} in_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] total_x;
		logic signed [COMP_W-1:0] total_y;
		logic signed [COMP_W-1:0] total_z;
		logic                     stopped_early;
	} out_t;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_SCALE  = 11'b000_0000_0010,
		S_LIM    = 11'b000_0000_0100,
		S_SQ     = 11'b000_0000_1000,
		S_CHK    = 11'b000_0001_0000,
		S_SQRT   = 11'b000_0010_0000,
		S_DSTART = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_NMUL   = 11'b001_0000_0000,
		S_ADD    = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	// what a length computation is for
	typedef enum logic [1:0] {
		PUR_CLAMP = 2'd0,
		PUR_TOT   = 2'd1,
		PUR_F     = 2'd2
	} pur_t;

endpackage

@@ design/sfc_isqrt.sv @@
module sfc_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfc_pkg::RAD_W-1:0]   rad,
	output logic                        done,
	output logic [sfc_pkg::LEN_W-1:0]   root
);
	import sfc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] n_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [LEN_W-1:0] root_q;
	logic [RAD_W:0]   trial;
	logic             ge;
	logic [RAD_W-1:0] res_next;

	always_comb begin
		trial = {1'b0, res_q} + {1'b0, bit_q};
		ge = {1'b0, n_q} >= trial;
		res_next = ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= rad;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (ge)
				n_q <= n_q - trial[RAD_W-1:0];
			res_q <= res_next;
			bit_q <= bit_q >> 2;
			if (bit_q[0])
				root_q <= res_next[LEN_W-1:0];
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ design/sfc_div.sv @@
module sfc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sfc_pkg::NUM_W-1:0]   num,
	input  logic [sfc_pkg::LEN_W-1:0]   den,
	output logic                        done,
	output logic [sfc_pkg::NUM_W-1:0]   quot
);
	import sfc_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [LEN_W:0]   rs;
	logic             ge;
	logic [LEN_W:0]   rs_sub;

	always_comb begin
		rs = {rem_q, quo_q[NUM_W-1]};
		ge = rs >= {1'b0, den_q};
		rs_sub = rs - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? rs_sub[LEN_W-1:0] : rs[LEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ design/steering_force_combiner_top.sv @@
// Steering force combiner: one input transaction per behaviour of a vehicle,
// one result transaction on the behaviour marked last.
// in_valid/in_ready carry a behaviour (force, weight, limit, enable, last);
// out_valid/out_ready carry the combined force and the stopped-early flag.
// cfg_we/cfg_data write the summing mode (0 prioritized, 1 weighted sum).
// Only one behaviour is worked on at a time; in_ready is high in idle only.
// Per transaction, a skipped behaviour takes the shortest path and a
// prioritized one that is clamped and truncated the longest. The cost is
// set by the shared iterative units: a square root yields one result bit
// per cycle, a normalize runs three divisions, one per component, each
// giving one quotient bit per cycle, and all products go through one
// 24x17 multiplier, one per cycle.
// Reset clears the running total, the stopped flag, the mode and the
// output valid flag.
// The result sits in an output register: while the receiver stalls, the
// next behaviours are still taken; only a second last-marked behaviour
// waits until the pending result has been taken.
module steering_force_combiner_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sfc_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output sfc_pkg::out_t   out_data,
	input  logic            cfg_we,
	input  logic            cfg_data
);
	import sfc_pkg::*;

	state_t state_q;
	pur_t   pur_q;
	in_t    item_q;
	logic   mode_q;
	logic   spent_q;
	logic   out_valid_q;
	out_t   out_q;
	logic [1:0] k_q;

	logic signed [COMP_W-1:0] tot_q [3];
	logic signed [COMP_W-1:0] v_q   [3];
	logic [SQ_W-1:0]   acc_q;
	logic [LIM_W-1:0]  lim_q;
	logic [LEN_W-1:0]  len_q;
	logic [MAXF_W-1:0] scale_q;
	logic [MAXF_W-1:0] rem_q;

	logic sq_start, sq_done;
	logic dv_start, dv_done;
	logic [LEN_W-1:0] root;
	logic [NUM_W-1:0] quot;

	logic signed [COMP_W-1:0]  raw_k, src_k, v_k;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod, prod_sh;
	logic [COMP_W:0]           v_abs;
	logic signed [MUL_A_W-1:0] q_s;
	logic signed [LEN_W+1:0]   rem_full;
	logic                      out_load;

	always_comb begin
		unique case (k_q)
			2'd0:    raw_k = item_q.force_x;
			2'd1:    raw_k = item_q.force_y;
			default: raw_k = item_q.force_z;
		endcase
		v_k = v_q[k_q];
		src_k = (pur_q == PUR_TOT) ? tot_q[k_q] : v_k;
		v_abs = v_k[COMP_W-1] ? -{v_k[COMP_W-1], v_k} : {v_k[COMP_W-1], v_k};
		if (len_q == '0)
			q_s = '0;
		else if (v_k[COMP_W-1])
			q_s = -{{(MUL_A_W-NUM_W){1'b0}}, quot};
		else
			q_s = {{(MUL_A_W-NUM_W){1'b0}}, quot};

		unique case (state_q)
			S_SCALE: begin
				mul_a = MUL_A_W'(raw_k);
				mul_b = MUL_B_W'(item_q.weight);
			end
			S_LIM: begin
				mul_a = {{(MUL_A_W-MAXF_W){1'b0}}, item_q.max_force};
				mul_b = {{(MUL_B_W-MAXF_W){1'b0}}, item_q.max_force};
			end
			S_SQ: begin
				mul_a = MUL_A_W'(src_k);
				mul_b = MUL_B_W'(src_k);
			end
			default: begin
				mul_a = q_s;
				mul_b = {{(MUL_B_W-MAXF_W){1'b0}}, scale_q};
			end
		endcase
		prod = mul_a * mul_b;
		prod_sh = prod >>> FRAC_W;

		rem_full = {3'b000, item_q.max_force} - {2'b00, root};
		out_load = (state_q == S_OUT) && item_q.last && (!out_valid_q || out_ready);

		sq_start = (state_q == S_CHK) &&
			!((pur_q == PUR_CLAMP) && (acc_q <= {{(SQ_W-LIM_W){1'b0}}, lim_q}));
		dv_start = (state_q == S_DSTART);
	end

	sfc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    ({acc_q, {FRAC_W{1'b0}}}),
		.done   (sq_done),
		.root   (root)
	);

	sfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    ({v_abs[NUM_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
		.den    (len_q),
		.done   (dv_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pur_q       <= PUR_CLAMP;
			mode_q      <= 1'b0;
			spent_q     <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			for (int i = 0; i < 3; i++)
				tot_q[i] <= '0;
		end else begin
			if (cfg_we)
				mode_q <= cfg_data;
			if (out_valid_q && out_ready && !out_load)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						k_q <= '0;
						state_q <= (in_data.enabled && !spent_q) ? S_SCALE : S_OUT;
					end
				end
				S_SCALE: begin
					if (k_q != 2'd2) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						acc_q <= '0;
						if (item_q.max_force != '0) begin
							state_q <= S_LIM;
						end else if (mode_q) begin
							state_q <= S_ADD;
						end else begin
							pur_q <= PUR_TOT;
							state_q <= S_SQ;
						end
					end
				end
				S_LIM: begin
					pur_q <= PUR_CLAMP;
					state_q <= S_SQ;
				end
				S_SQ: begin
					acc_q <= acc_q + SQ_W'(prod_sh[SQ_W-2:0]);
					if (k_q != 2'd2) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (sq_start) begin
						state_q <= S_SQRT;
					end else if (mode_q) begin
						state_q <= S_ADD;
					end else begin
						pur_q <= PUR_TOT;
						acc_q <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						len_q <= root;
						k_q <= '0;
						unique case (pur_q)
							PUR_CLAMP: begin
								scale_q <= item_q.max_force;
								state_q <= S_DSTART;
							end
							PUR_TOT: begin
								if (rem_full < 0) begin
									spent_q <= 1'b1;
									state_q <= S_OUT;
								end else begin
									rem_q <= rem_full[MAXF_W-1:0];
									pur_q <= PUR_F;
									acc_q <= '0;
									state_q <= S_SQ;
								end
							end
							default: begin
								if ({1'b0, root} < {2'b00, rem_q}) begin
									state_q <= S_ADD;
								end else begin
									scale_q <= rem_q;
									state_q <= S_DSTART;
								end
							end
						endcase
					end
				end
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (dv_done)
						state_q <= S_NMUL;
				end
				S_NMUL: begin
					if (k_q != 2'd2) begin
						k_q <= k_q + 1'b1;
						state_q <= S_DSTART;
					end else begin
						k_q <= '0;
						if (pur_q != PUR_CLAMP) begin
							state_q <= S_ADD;
						end else if (mode_q) begin
							state_q <= S_ADD;
						end else begin
							pur_q <= PUR_TOT;
							acc_q <= '0;
							state_q <= S_SQ;
						end
					end
				end
				S_ADD: begin
					for (int i = 0; i < 3; i++)
						tot_q[i] <= tot_q[i] + v_q[i];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!item_q.last) begin
						state_q <= S_IDLE;
					end else if (out_load) begin
						out_valid_q <= 1'b1;
						spent_q <= 1'b0;
						for (int i = 0; i < 3; i++)
							tot_q[i] <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			item_q <= in_data;
		if (state_q == S_LIM)
			lim_q <= prod_sh[LIM_W-1:0];
		if (state_q == S_SCALE || state_q == S_NMUL)
			v_q[k_q] <= prod_sh[COMP_W-1:0];
		if (out_load) begin
			out_q.total_x       <= tot_q[0];
			out_q.total_y       <= tot_q[1];
			out_q.total_z       <= tot_q[2];
			out_q.stopped_early <= spent_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_load_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == S_OUT) && item_q.last)
		else $error("result loaded outside a last transaction");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (tot_q[0] == '0) && (tot_q[1] == '0) && (tot_q[2] == '0) && !spent_q)
		else $error("running total not cleared after emit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

	a_spent_only_prio: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(spent_q) |-> $past(state_q == S_SQRT && pur_q == PUR_TOT))
		else $error("budget spent outside prioritized check");

endmodule
